[hdl/sdq_pkg.sv]
// shared types, constants and helpers of the sigma-delta quantizer
package sdq_pkg;

  localparam int FRAC_BITS = 20;
  localparam int SAMPLE_W  = 24;
  localparam int LEVEL_W   = 12;
  localparam int INTEG_W   = 32;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int MUL_STEPS = LEVEL_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W     = 5;

  localparam logic [12:0] COEF_FIRST = 13'd8077;
  localparam logic [LEVEL_W-1:0] LEVELS_RESET = 12'd125;

  typedef logic signed [INTEG_W-1:0] integ_t;
  typedef logic [LEVEL_W-1:0] level_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LVL,
    ST_DIV,
    ST_PROD,
    ST_UPD
  } state_t;

  // saturate a widened sum back to the integrator range
  function automatic integ_t sat_integ(input logic signed [INTEG_W+1:0] v);
    integ_t r;
    if ((v[INTEG_W+1:INTEG_W-1] == 3'b000) || (v[INTEG_W+1:INTEG_W-1] == 3'b111)) begin
      r = v[INTEG_W-1:0];
    end else if (v[INTEG_W+1]) begin
      r = {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(INTEG_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[hdl/sdq_in_if.sv]
// sample input channel
interface sdq_in_if import sdq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       channel;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink (input valid, input channel, input sample, output ready);
endinterface

[hdl/sdq_out_if.sv]
// level output channel
interface sdq_out_if import sdq_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   channel_out;
  level_t level;

  modport source (output valid, output channel_out, output level, input ready);
  modport sink (input valid, input channel_out, input level, output ready);
endinterface

[hdl/sdq_cfg_if.sv]
// levels register write channel
interface sdq_cfg_if import sdq_pkg::*; ();
  logic   valid;
  logic   ready;
  level_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/second_order_sigma_delta_quantizer.sv]
// second-order multibit sigma-delta quantizer, top level
// an accepted sample passes the multiply, level, divide, product and update states before its result is registered
// one item in flight: the 12-step shift-add level multiply and the 21-step restoring
//   feedback divide run serially, and a new sample is taken only while the block is idle
// reset (rst, synchronous): integrators cleared, levels back to 125, output empty
// the result register frees the input side while a result waits to be taken
module second_order_sigma_delta_quantizer import sdq_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic              clk,
  input  logic              rst,
  sdq_in_if.sink            in_ch,
  sdq_out_if.source         out_ch,
  sdq_cfg_if.sink           cfg
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t state, state_next;

  level_t levels;
  integ_t first_integ  [CHANNELS];
  integ_t second_integ [CHANNELS];

  logic [CH_W-1:0]    ch_idx;
  logic               channel_r;
  integ_t             s1;
  integ_t             s2;
  level_t             lv;
  logic               t_neg;
  logic               t_big;
  logic [QUO_W-1:0]   t_low;
  logic [32:0]        acc;
  level_t             lv_sr;
  logic [CNT_W-1:0]   cnt;
  level_t             level_r;
  logic               fb_neg;
  logic [13:0]        rem;
  logic [QUO_W-1:0]   nq;
  logic [QUO_W-1:0]   p1m;
  logic [QUO_W-1:0]   p2m;

  logic               out_valid;
  logic               out_channel;
  level_t             out_level;

  logic               in_fire;
  logic               upd_go;
  logic [CH_W-1:0]    idx_in;
  level_t             lv_in;
  logic signed [32:0] t_in;
  integ_t             s1_in;

  logic [33:0]        rnd;
  logic [12:0]        r_lvl;
  level_t             level_c;
  logic [12:0]        two_l;
  logic [12:0]        d_c;
  logic               neg_c;
  logic [13:0]        rem_sh;
  logic [13:0]        divisor;
  logic               ge;
  logic [23:0]        m5;
  logic [33:0]        m1;
  logic signed [33:0] new_second;
  logic signed [33:0] new_first;

  // input side
  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign idx_in      = (CHANNELS == 1) ? {CH_W{1'b0}} : CH_W'(in_ch.channel);
  assign lv_in       = (levels == '0) ? level_t'(1) : levels;
  assign s1_in       = sat_integ({{2{first_integ[idx_in][INTEG_W-1]}}, first_integ[idx_in]}
                       + {{(INTEG_W+2-SAMPLE_W){in_ch.sample[SAMPLE_W-1]}}, in_ch.sample});
  assign t_in        = {second_integ[idx_in][INTEG_W-1], second_integ[idx_in]}
                       + 33'sd1048576;

  // level from the product and feedback numerator
  assign rnd     = {1'b0, acc} + 34'd1048576;
  assign r_lvl   = rnd[33:21];
  assign two_l   = {level_c, 1'b0};
  assign neg_c   = (two_l < {1'b0, lv});
  assign d_c     = neg_c ? ({1'b0, lv} - two_l) : (two_l - {1'b0, lv});

  always_comb begin
    if (t_neg) begin
      level_c = '0;
    end else if (t_big || (r_lvl > {1'b0, lv})) begin
      level_c = lv;
    end else begin
      level_c = r_lvl[LEVEL_W-1:0];
    end
  end

  // restoring divide step
  assign divisor = {1'b0, lv, 1'b0};
  assign rem_sh  = {rem[12:0], nq[QUO_W-1]};
  assign ge      = (rem_sh >= divisor);

  // coefficient products
  assign m5 = {1'b0, nq, 2'b00} + {3'b000, nq} + 24'd2;
  assign m1 = 34'(nq) * 34'(COEF_FIRST) + 34'd8192;

  // integrator updates
  assign new_second = {{2{s2[INTEG_W-1]}}, s2} + {{2{s1[INTEG_W-1]}}, s1}
                      + (fb_neg ? $signed({13'b0, p2m}) : -$signed({13'b0, p2m}));
  assign new_first  = {{2{s1[INTEG_W-1]}}, s1}
                      + (fb_neg ? $signed({13'b0, p1m}) : -$signed({13'b0, p1m}));

  assign upd_go = (state == ST_UPD) && (!out_valid || out_ch.ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (cnt == CNT_W'(MUL_STEPS - 1)) state_next = ST_LVL;
      end
      ST_LVL: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = ST_PROD;
      end
      ST_PROD: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (upd_go) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // levels register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= LEVELS_RESET;
    end else if (cfg.valid) begin
      levels <= cfg.data;
    end
  end

  // integrator state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        first_integ[i]  <= '0;
        second_integ[i] <= '0;
      end
    end else if (upd_go) begin
      first_integ[ch_idx]  <= sat_integ(new_first);
      second_integ[ch_idx] <= sat_integ(new_second);
    end
  end

  // serial datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          ch_idx    <= idx_in;
          channel_r <= in_ch.channel;
          s1        <= s1_in;
          s2        <= second_integ[idx_in];
          lv        <= lv_in;
          lv_sr     <= lv_in;
          t_neg     <= t_in[32];
          t_big     <= !t_in[32] && (t_in[31:21] != '0);
          t_low     <= t_in[QUO_W-1:0];
          acc       <= '0;
          cnt       <= '0;
        end
      end
      ST_MUL: begin
        acc   <= {acc[31:0], 1'b0} + (lv_sr[LEVEL_W-1] ? {12'b0, t_low} : 33'd0);
        lv_sr <= {lv_sr[LEVEL_W-2:0], 1'b0};
        cnt   <= cnt + CNT_W'(1);
      end
      ST_LVL: begin
        level_r <= level_c;
        fb_neg  <= neg_c;
        rem     <= {1'b0, d_c};
        nq      <= QUO_W'(lv);
        cnt     <= '0;
      end
      ST_DIV: begin
        rem <= ge ? (rem_sh - divisor) : rem_sh;
        nq  <= {nq[QUO_W-2:0], ge};
        cnt <= cnt + CNT_W'(1);
      end
      ST_PROD: begin
        p2m <= m5[22:2];
        p1m <= QUO_W'(m1[33:14]);
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_go) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_channel <= channel_r;
      out_level   <= level_r;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.channel_out = out_channel;
  assign out_ch.level       = out_level;

  // checks
  a_start_mul: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_MUL)
    else $error("accepted item did not start the multiply");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> level_r <= lv)
    else $error("level above levels");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < divisor)
    else $error("divider remainder out of range");

  a_fb_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_PROD |-> nq <= QUO_W'(1 << FRAC_BITS))
    else $error("feedback magnitude above one");

endmodule

[verif/tb_top.sv]
// testbench for the sigma-delta quantizer: each level transfer checked against an expected channel and level
`timescale 1ns / 100ps

module tb_top;
  import sdq_pkg::*;

  localparam int NUM_CHANNELS = 2;
  localparam int DIRECTED_COUNT = 25;
  localparam int PHASE_COUNT = 9;
  localparam int PHASE_ITEMS = 46;
  localparam int LONG_BURST = 280;
  localparam int PREDICTED = -1;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = 40;
  localparam int COEF_BITS = 14;
  localparam longint FIRST_COEF = 8077;
  localparam longint SECOND_COEF = 20480;
  localparam longint INTEG_MAX = (longint'(1) <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_MIN = -(longint'(1) <<< (INTEG_W - 1));
  localparam longint ONE_Q20 = longint'(1) <<< FRAC_BITS;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum {SEG_NOISE, SEG_AUDIO, SEG_EXTREME} segment_t;

  typedef struct packed {
    logic                       ch;
    logic signed [SAMPLE_W-1:0] smp;
    int                         fixed_level;
  } stim_row_t;

  typedef struct packed {
    logic   ch;
    level_t level;
  } level_result_t;

  logic clk;
  logic rst;

  sdq_in_if  in_ch ();
  sdq_out_if out_ch ();
  sdq_cfg_if cfg ();

  second_order_sigma_delta_quantizer #(.CHANNELS(NUM_CHANNELS)) uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  // level after reset is round(0.5 * 125) on either channel
  stim_row_t directed_rows [DIRECTED_COUNT] = '{
    '{1'b0, SAMPLE_MAX, 63},
    '{1'b1, SAMPLE_MIN, 63},
    '{1'b0, SAMPLE_MAX, PREDICTED}, '{1'b0, SAMPLE_MAX, PREDICTED},
    '{1'b0, SAMPLE_MAX, PREDICTED}, '{1'b0, SAMPLE_MAX, PREDICTED},
    '{1'b0, SAMPLE_MAX, PREDICTED}, '{1'b0, SAMPLE_MAX, PREDICTED},
    '{1'b0, SAMPLE_MAX, PREDICTED}, '{1'b0, SAMPLE_MAX, PREDICTED},
    '{1'b0, SAMPLE_MAX, PREDICTED}, '{1'b0, SAMPLE_MAX, PREDICTED},
    '{1'b0, SAMPLE_MAX, PREDICTED}, '{1'b0, SAMPLE_MAX, PREDICTED},
    '{1'b1, SAMPLE_MIN, PREDICTED}, '{1'b1, SAMPLE_MIN, PREDICTED},
    '{1'b1, SAMPLE_MIN, PREDICTED}, '{1'b1, SAMPLE_MIN, PREDICTED},
    '{1'b1, SAMPLE_MIN, PREDICTED}, '{1'b1, SAMPLE_MIN, PREDICTED},
    '{1'b1, SAMPLE_MIN, PREDICTED}, '{1'b1, SAMPLE_MIN, PREDICTED},
    '{1'b0, 24'sd0, PREDICTED},
    '{1'b1, 24'sd1, PREDICTED},
    '{1'b0, -24'sd1, PREDICTED}
  };

  level_t phase_levels [PHASE_COUNT] = '{
    12'd1, 12'd4095, 12'd0, 12'd2, 12'd1000, 12'd125, 12'd37, 12'd4094, 12'd2731
  };

  integ_t        first_integ [NUM_CHANNELS];
  integ_t        second_integ [NUM_CHANNELS];
  level_t        model_levels;
  level_result_t expected_levels [$];
  level_result_t next_expected;
  int            mismatches = 0;
  int            send_idle_pct;
  int            recv_stall_pct;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint round_away_shift(input longint v, input int sh);
    longint half;
    half = longint'(1) <<< (sh - 1);
    if (v >= 0) begin
      return (v + half) >>> sh;
    end
    return -(((-v) + half) >>> sh);
  endfunction

  function automatic integ_t clamp_integ(input longint v);
    if (v > INTEG_MAX) begin
      return integ_t'(INTEG_MAX);
    end else if (v < INTEG_MIN) begin
      return integ_t'(INTEG_MIN);
    end
    return integ_t'(v);
  endfunction

  // advances the integrators of one channel and returns the quantized level
  function automatic level_t predict_level(input logic ch, input logic signed [SAMPLE_W-1:0] smp);
    int     idx;
    longint lv, s1, s2, num, lvl, fnum, mag, fb, p1, p2;
    idx = int'(ch) % NUM_CHANNELS;
    lv = (model_levels == '0) ? 1 : longint'(model_levels);
    s1 = longint'(clamp_integ(longint'(first_integ[idx]) + longint'(smp)));
    s2 = longint'(second_integ[idx]);
    num = (s2 + ONE_Q20) * lv;
    if (num < 0) begin
      lvl = 0;
    end else begin
      lvl = round_away_shift(num, FRAC_BITS + 1);
      if (lvl > lv) begin
        lvl = lv;
      end
    end
    fnum = (2 * lvl - lv) * ONE_Q20;
    mag = (fnum < 0) ? -fnum : fnum;
    mag = (2 * mag + lv) / (2 * lv);
    fb = (fnum < 0) ? -mag : mag;
    p2 = round_away_shift(fb * SECOND_COEF, COEF_BITS);
    p1 = round_away_shift(fb * FIRST_COEF, COEF_BITS);
    second_integ[idx] = clamp_integ(s2 + s1 - p2);
    first_integ[idx] = clamp_integ(s1 - p1);
    return level_t'(lvl);
  endfunction

  task automatic put_sample(input logic ch, input logic signed [SAMPLE_W-1:0] smp,
                            input int fixed_level);
    level_t        lvl;
    level_result_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.channel <= ch;
    in_ch.sample  <= smp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    lvl = predict_level(ch, smp);
    entry.ch = ch;
    entry.level = (fixed_level >= 0) ? level_t'(fixed_level) : lvl;
    expected_levels.push_back(entry);
  endtask

  task automatic wait_drained();
    while (expected_levels.size() != 0) @(posedge clk);
  endtask

  task automatic write_levels(input level_t value);
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    model_levels = value;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_idle_pct = 51;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct = 0;
        recv_stall_pct = 51;
      end
      default: begin
        send_idle_pct = 24;
        recv_stall_pct = 24;
      end
    endcase
  endtask

  // runs of noise, audio-like swings and saturating extremes
  task automatic send_random(input int count);
    int                         sent;
    int                         seg_len;
    int                         amp;
    segment_t                   kind;
    logic                       ch;
    logic                       positive;
    logic signed [SAMPLE_W-1:0] smp;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(9))
        0, 1, 2, 3: kind = SEG_NOISE;
        4, 5, 6:    kind = SEG_AUDIO;
        default:    kind = SEG_EXTREME;
      endcase
      seg_len = (kind == SEG_EXTREME) ? int'($urandom_range(60, 10)) : int'($urandom_range(25, 5));
      ch = 1'($urandom_range(1));
      positive = 1'($urandom_range(1));
      for (int k = 0; k < seg_len; k++) begin
        case (kind)
          SEG_NOISE: begin
            ch = 1'($urandom_range(1));
            smp = SAMPLE_W'($urandom);
          end
          SEG_AUDIO: begin
            ch = 1'($urandom_range(1));
            amp = int'($urandom_range(2 * ONE_Q20)) - int'(ONE_Q20);
            smp = SAMPLE_W'(amp);
          end
          default: begin
            smp = positive ? SAMPLE_MAX - SAMPLE_W'($urandom_range(255))
                           : SAMPLE_MIN + SAMPLE_W'($urandom_range(255));
          end
        endcase
        put_sample(ch, smp, PREDICTED);
      end
      sent += seg_len;
    end
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected transfer: ch %0d level %0d", out_ch.channel_out, out_ch.level);
        end
      end else begin
        next_expected = expected_levels.pop_front();
        if (next_expected.ch !== out_ch.channel_out || next_expected.level !== out_ch.level) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected ch %0d level %0d, got ch %0d level %0d",
                     next_expected.ch, next_expected.level, out_ch.channel_out, out_ch.level);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    model_levels = LEVELS_RESET;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      first_integ[i] = '0;
      second_integ[i] = '0;
    end
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.channel <= 1'b0;
    in_ch.sample  <= '0;
    cfg.valid     <= 1'b0;
    cfg.data      <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_idling(IDLE_NONE);
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      put_sample(directed_rows[i].ch, directed_rows[i].smp, directed_rows[i].fixed_level);
    end
    in_ch.valid <= 1'b0;

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      write_levels(phase_levels[ph]);
      set_idling(idle_mode_t'(ph % 4));
      // long enough to saturate the first integrator as well
      if (ph == 0) begin
        for (int k = 0; k < LONG_BURST; k++) begin
          put_sample(1'b0, SAMPLE_MAX, PREDICTED);
        end
      end
      send_random(PHASE_ITEMS);
      in_ch.valid <= 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
